// ----- sv/fqd_pkg.sv -----
package fqd_pkg;

  // Queue geometry.
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Result status codes.
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  // Command codes on the input channel.
  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ITER = 2'd3
  } cmd_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ENQ,
    OP_DEQ,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_ITER
  } state_t;

  // Control word shared by all cells: operation and the handle it concerns.
  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

endpackage

// ----- sv/fqd_cell.sv -----
module fqd_cell (
  input  logic                      clk,
  input  fqd_pkg::cell_ctrl_t       ctrl,
  input  logic                      valid_i,
  input  logic                      prev_valid_i,
  input  logic                      next_valid_i,
  input  logic                      prev_hit_i,
  input  logic [fqd_pkg::DATA_W-1:0] next_data_i,
  input  logic [fqd_pkg::DATA_W-1:0] head_data_i,
  output logic                      hit_o,
  output logic [fqd_pkg::DATA_W-1:0] data_o
);
  import fqd_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              match;

  // A cell matches when it holds a live entry equal to the handle. The
  // hit chain makes the first match and every cell behind it close the gap.
  assign match = valid_i && (data_r == ctrl.data);
  assign hit_o = prev_hit_i | match;

  // Next entry value for each operation.
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_ENQ: begin
        // The first free cell takes the new handle.
        if (!valid_i && prev_valid_i) begin
          data_nxt = ctrl.data;
        end
      end
      OP_DEQ: begin
        data_nxt = next_data_i;
      end
      OP_DEL: begin
        if (hit_o) begin
          data_nxt = next_data_i;
        end
      end
      OP_ROT: begin
        // The tail cell wraps the head entry around.
        if (next_valid_i) begin
          data_nxt = next_data_i;
        end else if (valid_i) begin
          data_nxt = head_data_i;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ----- sv/fifo_queue_with_delete.sv -----
// Bounded FIFO of nonzero 32-bit handles with delete-by-value.
// Command channel: in_cmd and in_data_in are taken at a rising edge where
// start is high and busy is low. Commands: enqueue, dequeue, delete the
// first matching entry (entries behind it move up), and iterate.
// Result channel: out_valid marks one result per cycle on the out_ ports;
// the receiver takes it in that cycle and cannot stall the block.
// Every result carries the queue length after the command in out_count,
// and out_last marks the final result of a command.
// Enqueue, dequeue and delete give one result in the cycle after
// acceptance and can be issued back to back, one per cycle: the entries
// live in a chain of cells that compare and shift in parallel.
// Iterate holds busy high while it walks the queue and gives one result
// per cycle, head first, registered from the iterate state, by rotating
// the chain one place a cycle; an empty queue gives a single result in
// the cycle after acceptance. A new command is taken the cycle busy is low.
// Reset (rst_n low, synchronous) empties the queue and drops any
// iteration in progress; entry storage itself is not cleared.
module fifo_queue_with_delete (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_cmd,
  input  logic [fqd_pkg::DATA_W-1:0] in_data_in,
  output logic                       out_valid,
  output logic                       out_status,
  output logic                       out_has_item,
  output logic [fqd_pkg::DATA_W-1:0] out_data_out,
  output logic [fqd_pkg::CNT_W-1:0]  out_count,
  output logic                       out_last
);
  import fqd_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [CNT_W-1:0]  iter_left_r, iter_left_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              status_r, status_nxt;
  logic              has_item_r, has_item_nxt;
  logic [DATA_W-1:0] data_out_r, data_out_nxt;
  logic              last_r, last_nxt;

  cell_ctrl_t        ctrl;
  cmd_t              cmd;
  logic              accept;
  logic [DEPTH-1:0]  valid;
  logic [DEPTH-1:0]  prev_valid;
  logic [DEPTH-1:0]  next_valid;
  logic [DEPTH-1:0]  prev_hit;
  logic [DEPTH-1:0]  hit;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] next_data [DEPTH];

  assign cmd    = cmd_t'(in_cmd);
  assign busy   = (state_r == ST_ITER);
  assign accept = start && !busy;

  // Chain of cells; occupancy decodes into the live-entry map.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid[i] = (CNT_W'(i) < occ_r);

    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b1;
      assign prev_hit[i]   = 1'b0;
    end else begin : g_body
      assign prev_valid[i] = valid[i-1];
      assign prev_hit[i]   = hit[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid[i] = 1'b0;
      assign next_data[i]  = '0;
    end else begin : g_link
      assign next_valid[i] = valid[i+1];
      assign next_data[i]  = cell_data[i+1];
    end

    fqd_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .valid_i      (valid[i]),
      .prev_valid_i (prev_valid[i]),
      .next_valid_i (next_valid[i]),
      .prev_hit_i   (prev_hit[i]),
      .next_data_i  (next_data[i]),
      .head_data_i  (cell_data[0]),
      .hit_o        (hit[i]),
      .data_o       (cell_data[i])
    );
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (cmd == CMD_ITER) && (occ_r != '0)) begin
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (iter_left_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Cell operation, occupancy and result for each transaction.
  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.data     = in_data_in;
    occ_nxt       = occ_r;
    iter_left_nxt = iter_left_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STAT_OK;
    has_item_nxt  = 1'b0;
    data_out_nxt  = '0;
    last_nxt      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (cmd)
            CMD_ENQ: begin
              if ((in_data_in == '0) || (occ_r == CNT_W'(DEPTH))) begin
                status_nxt = STAT_ERR;
              end else begin
                ctrl.op = OP_ENQ;
                occ_nxt = occ_r + CNT_W'(1);
              end
            end
            CMD_DEQ: begin
              if (occ_r == '0) begin
                status_nxt = STAT_ERR;
              end else begin
                ctrl.op      = OP_DEQ;
                occ_nxt      = occ_r - CNT_W'(1);
                has_item_nxt = 1'b1;
                data_out_nxt = cell_data[0];
              end
            end
            CMD_DEL: begin
              if ((in_data_in == '0) || (occ_r == '0)) begin
                status_nxt = STAT_ERR;
              end else begin
                // Cells shift only from a match on, so a miss changes nothing.
                ctrl.op = OP_DEL;
                if (hit[DEPTH-1]) begin
                  occ_nxt = occ_r - CNT_W'(1);
                end else begin
                  status_nxt = STAT_ERR;
                end
              end
            end
            CMD_ITER: begin
              if (occ_r != '0) begin
                out_valid_nxt = 1'b0;
                iter_left_nxt = occ_r;
              end
            end
            default: begin
              status_nxt = STAT_ERR;
            end
          endcase
        end
      end
      ST_ITER: begin
        // Emit the head and rotate the chain by one place.
        ctrl.op       = OP_ROT;
        out_valid_nxt = 1'b1;
        has_item_nxt  = 1'b1;
        data_out_nxt  = cell_data[0];
        last_nxt      = (iter_left_r == CNT_W'(1));
        iter_left_nxt = iter_left_r - CNT_W'(1);
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      iter_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      iter_left_r <= iter_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    has_item_r <= has_item_nxt;
    data_out_r <= data_out_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_has_item = has_item_r;
  assign out_data_out = data_out_r;
  assign out_count    = occ_r;
  assign out_last     = last_r;

endmodule

// ----- sv/fqd_checker.sv -----
module fqd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_status,
  input logic                       out_has_item,
  input logic [fqd_pkg::DATA_W-1:0] out_data_out,
  input logic [fqd_pkg::CNT_W-1:0]  out_count,
  input logic                       out_last
);
  import fqd_pkg::*;

  // A result that is not the last of its transaction is followed directly
  // by the next one.
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("iterate burst has a gap");

  // An emitted entry is never the invalid zero handle, and errors carry none.
  a_item_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_item |-> (out_data_out != '0) && (out_status == STAT_OK))
    else $error("bad entry on result");

  // The reported length never exceeds the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(DEPTH)))
    else $error("count beyond depth");

  // Iteration ends together with its final result.
  a_iter_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_last)
    else $error("busy dropped without last result");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_has_item (out_has_item),
  .out_data_out (out_data_out),
  .out_count    (out_count),
  .out_last     (out_last)
);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import fqd_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int SEGMENTS    = 9;
  localparam int SEG_ITEMS   = 28;

  // Mix of commands used by one stretch of random traffic.
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_t;

  // One result transaction as seen on the out_ ports.
  typedef struct packed {
    logic              status;
    logic              has_item;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  count;
    logic              last;
  } queue_result_t;

  // Shadow copy of the queue: predicts the results of each accepted command
  // and checks what the block returns against them, oldest first.
  class queue_shadow;
    logic [DATA_W-1:0] entries[$];
    queue_result_t     awaited[$];
    int                mismatches;
    int                n_cmds;
    int                n_results;
    int                full_refusals;
    int                longest_walk;

    function int pending();
      return awaited.size();
    endfunction

    function int size();
      return entries.size();
    endfunction

    function logic [DATA_W-1:0] pick_entry();
      return entries[$urandom_range(0, entries.size() - 1)];
    endfunction

    // The count field always reflects the length after the command.
    function void expect_result(logic st, logic has, logic [DATA_W-1:0] d, logic lst);
      queue_result_t r;
      r.status   = st;
      r.has_item = has;
      r.data_out = d;
      r.count    = CNT_W'(entries.size());
      r.last     = lst;
      awaited.push_back(r);
    endfunction

    function void accept_cmd(cmd_t c, logic [DATA_W-1:0] h);
      int                idx;
      logic [DATA_W-1:0] v;
      n_cmds++;
      case (c)
        CMD_ENQ: begin
          if (h == '0 || entries.size() >= DEPTH) begin
            if (h != '0) full_refusals++;
            expect_result(STAT_ERR, 1'b0, '0, 1'b1);
          end else begin
            entries.push_back(h);
            expect_result(STAT_OK, 1'b0, '0, 1'b1);
          end
        end
        CMD_DEQ: begin
          if (entries.size() == 0) begin
            expect_result(STAT_ERR, 1'b0, '0, 1'b1);
          end else begin
            v = entries.pop_front();
            expect_result(STAT_OK, 1'b1, v, 1'b1);
          end
        end
        CMD_DEL: begin
          idx = -1;
          if (h != '0) begin
            for (int i = 0; i < entries.size(); i++) begin
              if (idx < 0 && entries[i] == h) idx = i;
            end
          end
          if (idx < 0) begin
            expect_result(STAT_ERR, 1'b0, '0, 1'b1);
          end else begin
            entries.delete(idx);
            expect_result(STAT_OK, 1'b0, '0, 1'b1);
          end
        end
        default: begin
          // Iterate walks head to tail; an empty queue still gives one result.
          if (entries.size() == 0) begin
            expect_result(STAT_OK, 1'b0, '0, 1'b1);
          end else begin
            if (entries.size() > longest_walk) longest_walk = entries.size();
            for (int i = 0; i < entries.size(); i++) begin
              expect_result(STAT_OK, 1'b1, entries[i], i == entries.size() - 1);
            end
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      n_results++;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
      compare_field("has_item", DATA_W'(want.has_item), DATA_W'(got.has_item));
      compare_field("data_out", want.data_out, got.data_out);
      compare_field("count", DATA_W'(want.count), DATA_W'(got.count));
      compare_field("last", DATA_W'(want.last), DATA_W'(got.last));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd = CMD_ENQ;
  logic [DATA_W-1:0] in_data_in = '0;
  logic              out_valid;
  logic              out_status;
  logic              out_has_item;
  logic [DATA_W-1:0] out_data_out;
  logic [CNT_W-1:0]  out_count;
  logic              out_last;

  queue_shadow shadow = new();
  int          burst_left = 0;
  int          cycle_count = 0;

  fifo_queue_with_delete uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_has_item (out_has_item),
    .out_data_out (out_data_out),
    .out_count    (out_count),
    .out_last     (out_last)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Every result strobe is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      shadow.check_result({out_status, out_has_item, out_data_out, out_count, out_last});
    end
  end

  // Watchdog against a hung handshake or lost results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sends one command transaction; the sender works in bursts with random
  // gaps between them, and start stays high across a burst.
  task automatic send_cmd(input cmd_t c, input logic [DATA_W-1:0] h);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    in_cmd     <= c;
    in_data_in <= h;
    do @(posedge clk); while (busy);
    shadow.accept_cmd(c, h);
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Handles favor repeats and entries already queued so that deletes hit.
  function automatic logic [DATA_W-1:0] pick_handle(bit for_delete);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (shadow.size() != 0 && roll < (for_delete ? 70 : 20)) return shadow.pick_entry();
    if (roll < (for_delete ? 80 : 50)) return DATA_W'($urandom_range(1, 8));
    return $urandom();
  endfunction

  function automatic cmd_t pick_cmd(mix_t mix);
    int roll;
    int enq_w;
    int deq_w;
    int del_w;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        enq_w = 80; deq_w = 5; del_w = 5;
      end
      MIX_DRAIN: begin
        enq_w = 15; deq_w = 40; del_w = 35;
      end
      default: begin
        enq_w = 35; deq_w = 25; del_w = 25;
      end
    endcase
    if (roll < enq_w) return CMD_ENQ;
    if (roll < enq_w + deq_w) return CMD_DEQ;
    if (roll < enq_w + deq_w + del_w) return CMD_DEL;
    return CMD_ITER;
  endfunction

  initial begin
    mix_t mix;
    cmd_t c;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-queue errors, null handles, extreme values, duplicates,
    // delete from the middle and the tail, ignored operands.
    send_cmd(CMD_ITER, 32'h0000_0000);
    send_cmd(CMD_DEQ,  32'hFFFF_FFFF);
    send_cmd(CMD_DEL,  32'h0000_0005);
    send_cmd(CMD_DEL,  32'h0000_0000);
    send_cmd(CMD_ENQ,  32'h0000_0000);
    send_cmd(CMD_ENQ,  32'hFFFF_FFFF);
    send_cmd(CMD_ENQ,  32'h0000_0001);
    send_cmd(CMD_ENQ,  32'h8000_0000);
    send_cmd(CMD_ENQ,  32'h0000_0001);
    send_cmd(CMD_ENQ,  32'h7FFF_FFFF);
    send_cmd(CMD_ITER, 32'hA5A5_A5A5);
    send_cmd(CMD_DEL,  32'h0000_0001);
    send_cmd(CMD_DEL,  32'h1234_5678);
    send_cmd(CMD_DEL,  32'h0000_0000);
    send_cmd(CMD_DEQ,  32'h5A5A_5A5A);
    send_cmd(CMD_ITER, 32'hFFFF_FFFF);
    send_cmd(CMD_DEL,  32'h7FFF_FFFF);
    send_cmd(CMD_DEQ,  32'h0000_0000);
    send_cmd(CMD_DEQ,  32'h0000_0000);
    send_cmd(CMD_DEQ,  32'h0000_0000);
    send_cmd(CMD_ITER, 32'h0000_0000);
    wait_drained();

    // Random traffic in stretches; the first fills the queue past full and
    // the second drains it, later ones pick a mix at random.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 0) mix = MIX_FILL;
      else if (seg == 1) mix = MIX_DRAIN;
      else mix = mix_t'($urandom_range(0, 2));
      for (int k = 0; k < SEG_ITEMS; k++) begin
        c = pick_cmd(mix);
        case (c)
          CMD_ENQ: send_cmd(c, pick_handle(1'b0));
          CMD_DEL: send_cmd(c, pick_handle(1'b1));
          default: send_cmd(c, $urandom());
        endcase
      end
      if (seg == 1 || $urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d commands and checked %0d results; %0d enqueues hit a full queue.",
             shadow.n_cmds, shadow.n_results, shadow.full_refusals);
    $display("Longest iterate walked %0d entries; %0d mismatches seen.",
             shadow.longest_walk, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- fifo_queue_with_delete.f -----
sv/fqd_pkg.sv
sv/fqd_cell.sv
sv/fifo_queue_with_delete.sv
sv/fqd_checker.sv
dv/tb.sv
